// ===== rtl/lptf_pkg.sv =====
// Package with shared types, constants and the arctangent table of the point transform.
`default_nettype none
package lptf_pkg;

  localparam int unsigned CordicStages = 16;
  localparam int unsigned AtanEntries = 24;
  localparam int unsigned AtanIdxW = $clog2(AtanEntries);
  localparam int unsigned NumStages =
      (CordicStages < AtanEntries) ? CordicStages : AtanEntries;
  localparam int unsigned StageIdxW = (NumStages > 1) ? $clog2(NumStages) : 1;
  localparam logic [15:0] GainQ16 = 16'd39797;

  // Coordinate width: Q8 mm with CORDIC growth and offsets.
  localparam int unsigned CoordW = 28;
  localparam int unsigned AngW = 34;

  localparam logic [2:0] RegSensorX = 3'd0;
  localparam logic [2:0] RegSensorY = 3'd1;
  localparam logic [2:0] RegSensorYaw = 3'd2;
  localparam logic [2:0] RegFront = 3'd3;
  localparam logic [2:0] RegRear = 3'd4;
  localparam logic [2:0] RegLeft = 3'd5;
  localparam logic [2:0] RegRight = 3'd6;

  typedef struct packed {
    logic [15:0]        beam_range_mm;
    logic signed [15:0] beam_angle;
    logic               beam_valid;
    logic               scan_end;
  } beam_t;

  typedef struct packed {
    logic               point_kept;
    logic [15:0]        point_radius_mm;
    logic signed [15:0] point_bearing;
    logic               scan_last;
  } point_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [AngW-1:0]   z;
    logic                     keep;
    logic                     last;
    logic                     origin;
  } cell_t;

  function automatic logic signed [AngW-1:0] atan_of(input logic [AtanIdxW-1:0] idx);
    logic signed [AngW-1:0] v;
    case (idx)
      5'd0: v = 34'sd536870912;
      5'd1: v = 34'sd316933406;
      5'd2: v = 34'sd167458907;
      5'd3: v = 34'sd85004756;
      5'd4: v = 34'sd42667331;
      5'd5: v = 34'sd21354465;
      5'd6: v = 34'sd10680862;
      5'd7: v = 34'sd5340757;
      5'd8: v = 34'sd2670675;
      5'd9: v = 34'sd1335343;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lptf_cell.sv =====
// One CORDIC micro-rotation cell, in rotation or vectoring mode, with its output register.
`default_nettype none
module lptf_cell (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic                          vectoring,
  input  wire logic [lptf_pkg::StageIdxW-1:0] shift,
  input  wire lptf_pkg::cell_t               din,
  output lptf_pkg::cell_t                    dout
);

  lptf_pkg::cell_t nxt;
  logic signed [lptf_pkg::CoordW-1:0] xs;
  logic signed [lptf_pkg::CoordW-1:0] ys;
  logic signed [lptf_pkg::AngW-1:0] da;
  logic dir;

  always_comb begin
    xs = din.x >>> shift;
    ys = din.y >>> shift;
    da = lptf_pkg::atan_of(lptf_pkg::AtanIdxW'(shift));
    // dir high: rotate counterclockwise (x - y>>i, y + x>>i).
    dir = vectoring ? din.y[lptf_pkg::CoordW-1] : ~din.z[lptf_pkg::AngW-1];
    nxt = din;
    if (dir) begin
      nxt.x = din.x - ys;
      nxt.y = din.y + xs;
      nxt.z = din.z - da;
    end else begin
      nxt.x = din.x + ys;
      nxt.y = din.y - xs;
      nxt.z = din.z + da;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lptf_chain.sv =====
// A row of CORDIC cells with a valid bit per cell, advancing together when not stalled.
`default_nettype none
module lptf_chain (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            vectoring,
  input  wire logic            in_valid,
  input  wire lptf_pkg::cell_t din,
  output lptf_pkg::cell_t      dout,
  output logic                 out_valid
);

  lptf_pkg::cell_t link [lptf_pkg::NumStages+1];
  logic [lptf_pkg::NumStages:0] vld;

  assign link[0] = din;
  assign vld[0] = in_valid;

  for (genvar g = 0; g < lptf_pkg::NumStages; g++) begin : g_cell
    lptf_cell u_cell (
      .clk(clk),
      .en(en),
      .vectoring(vectoring),
      .shift(lptf_pkg::StageIdxW'(g)),
      .din(link[g]),
      .dout(link[g+1])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end
  end

  assign dout = link[lptf_pkg::NumStages];
  assign out_valid = vld[lptf_pkg::NumStages];

endmodule
`default_nettype wire

// ===== rtl/lidar_point_transform_filter.sv =====
// Top level: lidar beam to robot-frame polar point with footprint filter.
// Usage:
//   Beams enter on beam / beam_valid_in / beam_stall; one transfer per cycle
//   is taken when the block is not stalled downstream. Results leave on
//   point / point_valid / point_stall, exactly one per beam, in order.
//   Configuration is written on cfg_valid / cfg_ready / cfg_index / cfg_data
//   while the block is idle; cfg_ready is always high.
//   The pipeline is an input register, a rotation chain of one cell per
//   stage, an offset and footprint stage, a vectoring chain, a gain multiply
//   stage and the output register.
//   Throughput is one beam per cycle while the block is not stalled.
//   The whole pipeline advances as one; it holds while the output register
//   is full and stalled, and beam_stall is then high.
//   Synchronous reset empties the pipeline and loads the register defaults.
`default_nettype none
module lidar_point_transform_filter (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire lptf_pkg::beam_t beam,
  input  wire logic            beam_valid_in,
  output logic                 beam_stall,
  output lptf_pkg::point_t     point,
  output logic                 point_valid,
  input  wire logic            point_stall,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [15:0]     cfg_data
);

  localparam int unsigned W = lptf_pkg::CoordW;
  localparam int unsigned A = lptf_pkg::AngW;

  logic signed [15:0] sensor_x_mm, sensor_y_mm, sensor_yaw;
  logic [14:0] footprint_front_mm, footprint_rear_mm;
  logic [14:0] footprint_left_mm, footprint_right_mm;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_x_mm <= '0;
      sensor_y_mm <= '0;
      sensor_yaw <= '0;
      footprint_front_mm <= 15'd330;
      footprint_rear_mm <= 15'd290;
      footprint_left_mm <= 15'd250;
      footprint_right_mm <= 15'd250;
    end else if (cfg_valid) begin
      case (cfg_index)
        lptf_pkg::RegSensorX: sensor_x_mm <= cfg_data;
        lptf_pkg::RegSensorY: sensor_y_mm <= cfg_data;
        lptf_pkg::RegSensorYaw: sensor_yaw <= cfg_data;
        lptf_pkg::RegFront: footprint_front_mm <= cfg_data[14:0];
        lptf_pkg::RegRear: footprint_rear_mm <= cfg_data[14:0];
        lptf_pkg::RegLeft: footprint_left_mm <= cfg_data[14:0];
        lptf_pkg::RegRight: footprint_right_mm <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !(point_valid && point_stall);
  assign beam_stall = !en;

  // Stage 0: input register with range times gain.
  logic v0;
  lptf_pkg::beam_t b0;
  logic [31:0] prod0;
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= beam_valid_in;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b0 <= beam;
      prod0 <= beam.beam_range_mm * lptf_pkg::GainQ16;
    end
  end

  // Fold into the right half plane before the rotation chain.
  lptf_pkg::cell_t rin;
  logic signed [15:0] ang;
  logic signed [15:0] angf;
  logic signed [W-1:0] x0;
  always_comb begin
    ang = b0.beam_angle + sensor_yaw;
    // In 16 bits, adding a half turn wraps the same as subtracting one.
    angf = ang + 16'sh8000;
    x0 = W'(signed'({1'b0, prod0[31:8]}));
    rin.y = '0;
    rin.keep = b0.beam_valid;
    rin.last = b0.scan_end;
    rin.origin = 1'b0;
    if (ang > 16'sd16384) begin
      rin.x = -x0;
      rin.z = A'(angf) <<< 16;
    end else if (ang < -16'sd16384) begin
      rin.x = -x0;
      rin.z = A'(angf) <<< 16;
    end else begin
      rin.x = x0;
      rin.z = A'(ang) <<< 16;
    end
  end

  lptf_pkg::cell_t rout;
  logic rv;
  lptf_chain u_rot (
    .clk(clk), .rst(rst), .en(en), .vectoring(1'b0),
    .in_valid(v0), .din(rin), .dout(rout), .out_valid(rv)
  );

  // Offset and footprint stage.
  logic signed [W-1:0] px, py;
  logic signed [W-1:0] lim_front, lim_rear, lim_left, lim_right;
  logic pkeep;
  always_comb begin
    px = rout.x + (W'(sensor_x_mm) <<< 8);
    py = rout.y + (W'(sensor_y_mm) <<< 8);
    lim_front = W'(signed'({1'b0, footprint_front_mm})) <<< 8;
    lim_rear = W'(signed'({1'b0, footprint_rear_mm})) <<< 8;
    lim_left = W'(signed'({1'b0, footprint_left_mm})) <<< 8;
    lim_right = W'(signed'({1'b0, footprint_right_mm})) <<< 8;
    pkeep = rout.keep && !(px < lim_front && px > -lim_rear &&
                           py < lim_left && py > -lim_right);
  end

  logic v1;
  lptf_pkg::cell_t c1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= rv;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c1.x <= px;
      c1.y <= py;
      c1.z <= '0;
      c1.keep <= pkeep;
      c1.last <= rout.last;
      c1.origin <= (px == '0) && (py == '0);
    end
  end

  // Left half plane starts from a half turn.
  lptf_pkg::cell_t vin;
  always_comb begin
    vin = c1;
    if (c1.x < 0) begin
      vin.x = -c1.x;
      vin.y = -c1.y;
      vin.z = A'(64'sd2147483648);
    end
  end

  lptf_pkg::cell_t vout;
  logic vv;
  lptf_chain u_vec (
    .clk(clk), .rst(rst), .en(en), .vectoring(1'b1),
    .in_valid(v1), .din(vin), .dout(vout), .out_valid(vv)
  );

  // Gain multiply stage.
  logic v2;
  logic signed [W+17:0] prod2;
  logic signed [A-1:0] z2;
  logic keep2, last2, origin2;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= vv;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      prod2 <= (W+18)'(vout.x) * (W+18)'(signed'({1'b0, lptf_pkg::GainQ16}));
      z2 <= vout.z;
      keep2 <= vout.keep;
      last2 <= vout.last;
      origin2 <= vout.origin;
    end
  end

  logic signed [W+17:0] rnd;
  logic signed [W-7:0] rq;
  logic signed [A-1:0] zr;
  lptf_pkg::point_t res;
  always_comb begin
    rnd = prod2 + (W+18)'(32'sd8388608);
    rq = rnd[W+17:24];
    zr = z2 + A'(32'sd32768);
    res.scan_last = last2;
    res.point_kept = keep2;
    res.point_radius_mm = '0;
    res.point_bearing = '0;
    if (keep2) begin
      if (rq < 0) begin
        res.point_radius_mm = '0;
      end else if (rq > 65535) begin
        res.point_radius_mm = 16'hFFFF;
      end else begin
        res.point_radius_mm = rq[15:0];
      end
      // A point at the origin has no direction; its bearing is zero.
      if (!origin2) begin
        res.point_bearing = zr[31:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (en) begin
      point_valid <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      point <= res;
    end
  end

endmodule
`default_nettype wire

// ===== tb/lptf_checker.sv =====
// Checker for the lidar point transform: predicts each point and compares transfers.
`timescale 1ns / 1ps
`default_nettype none
module lptf_checker (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire lptf_pkg::beam_t  beam,
  input  wire logic             beam_valid_in,
  input  wire logic             beam_stall,
  input  wire lptf_pkg::point_t point,
  input  wire logic             point_valid,
  input  wire logic             point_stall,
  input  wire logic             cfg_valid,
  input  wire logic             cfg_ready,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [15:0]      cfg_data,
  output int                    fail_count,
  output int                    points_pending
);

  localparam longint ATAN [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340757, 2670675, 1335343, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  longint off_x, off_y, yaw, front, rear, left, right;
  lptf_pkg::point_t expected_points[$];

  function automatic longint sx16(longint v);
    v = v & 64'hFFFF;
    return (v >= 32768) ? v - 65536 : v;
  endfunction

  function automatic lptf_pkg::point_t transform_beam(lptf_pkg::beam_t b);
    longint r, ang, x, y, z, nx, ny, rv;
    lptf_pkg::point_t p;
    r = b.beam_range_mm;
    ang = sx16(longint'(b.beam_angle) + yaw);
    p = '0;
    p.scan_last = b.scan_end;
    x = (r * 39797) >>> 8;
    if (ang > 16384) begin
      ang -= 32768;
      x = -x;
    end else if (ang < -16384) begin
      ang += 32768;
      x = -x;
    end
    y = 0;
    z = ang * 65536;
    for (int i = 0; i < lptf_pkg::NumStages; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= ATAN[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += ATAN[i];
      end
      x = nx;
      y = ny;
    end
    x += off_x * 256;
    y += off_y * 256;
    if (b.beam_valid && !(x < front * 256 && x > -rear * 256 &&
                          y < left * 256 && y > -right * 256)) begin
      p.point_kept = 1'b1;
      if (x != 0 || y != 0) begin
        z = 0;
        if (x < 0) begin
          x = -x;
          y = -y;
          z = 64'd2147483648;
        end
        for (int i = 0; i < lptf_pkg::NumStages; i++) begin
          if (y < 0) begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z -= ATAN[i];
          end else begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z += ATAN[i];
          end
          x = nx;
          y = ny;
        end
        rv = (x * 39797 + 8388608) >>> 24;
        if (rv < 0) rv = 0;
        if (rv > 65535) rv = 65535;
        p.point_radius_mm = rv[15:0];
        p.point_bearing = 16'((z + 32768) >>> 16);
      end
    end
    return p;
  endfunction

  always @(posedge clk) begin
    lptf_pkg::point_t e;
    if (rst) begin
      off_x <= 0; off_y <= 0; yaw <= 0;
      front <= 330; rear <= 290; left <= 250; right <= 250;
      fail_count <= 0;
      expected_points.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lptf_pkg::RegSensorX: off_x <= sx16(cfg_data);
          lptf_pkg::RegSensorY: off_y <= sx16(cfg_data);
          lptf_pkg::RegSensorYaw: yaw <= sx16(cfg_data);
          lptf_pkg::RegFront: front <= cfg_data[14:0];
          lptf_pkg::RegRear: rear <= cfg_data[14:0];
          lptf_pkg::RegLeft: left <= cfg_data[14:0];
          lptf_pkg::RegRight: right <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (beam_valid_in && !beam_stall) begin
        expected_points.insert(expected_points.size(), transform_beam(beam));
      end
      if (point_valid && !point_stall) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected point transfer %h", $time, point);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_points.pop_front();
          if (e !== point) begin
            $display("%0t: point mismatch expected kept=%0d r=%0d b=%0d last=%0d",
                     $time, e.point_kept, e.point_radius_mm, e.point_bearing,
                     e.scan_last);
            $display("%0t:                actual   kept=%0d r=%0d b=%0d last=%0d",
                     $time, point.point_kept, point.point_radius_mm,
                     point.point_bearing, point.scan_last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  // The push of the current edge is visible here one delta later, which is fine for idling.
  assign points_pending = expected_points.size();
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench top: drives beams and register writes and gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  localparam int LATENCY = 2 * lptf_pkg::NumStages + 4;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk, rst;
  lptf_pkg::beam_t beam;
  logic beam_valid_in, beam_stall;
  lptf_pkg::point_t point;
  logic point_valid;
  logic point_stall = 1'b0;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;
  int fail_count, points_pending;
  longint cycle_count = 0;

  lidar_point_transform_filter uut (.*);

  lptf_checker point_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Receiver stalls in its own mode: none, light or heavy, switched now and then.
  int stall_mode = 0;
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: point_stall <= 1'b0;
      1: point_stall <= ($urandom_range(0, 3) == 0);
      default: point_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // The first edge makes the last beam transfer visible in the pending count.
  task automatic drain_points();
    @(posedge clk);
    while (points_pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One beam transfer; with hold set, keeps valid high for back-to-back calls.
  task automatic send_beam(lptf_pkg::beam_t b, bit hold);
    beam <= b;
    beam_valid_in <= 1'b1;
    @(posedge clk iff !beam_stall);
    if (!hold) beam_valid_in <= 1'b0;
  endtask

  function automatic lptf_pkg::beam_t make_beam(logic [15:0] r, logic [15:0] a, bit v, bit e);
    lptf_pkg::beam_t b;
    b.beam_range_mm = r;
    b.beam_angle = a;
    b.beam_valid = v;
    b.scan_end = e;
    return b;
  endfunction

  task automatic random_beams(int count);
    int burst;
    logic [15:0] r;
    while (count > 0) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && count > 0; k++, count--) begin
        // Mostly realistic ranges, so the footprint edge and small radii get hit.
        case ($urandom_range(0, 3))
          0: r = 16'($urandom);
          1: r = 16'($urandom_range(0, 700));
          default: r = 16'($urandom_range(0, 8000));
        endcase
        send_beam(make_beam(r, 16'($urandom), $urandom_range(0, 7) != 0,
                            $urandom_range(0, 15) == 0), k < burst - 1 && count > 1);
      end
      beam_valid_in <= 1'b0;
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 30)) @(posedge clk);
    end
    beam_valid_in <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    beam = '0;
    beam_valid_in = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed beams at reset footprint: extremes, invalid, edge, origin.
    send_beam(make_beam(16'd0, 16'd0, 1, 0), 1);
    send_beam(make_beam(16'hFFFF, 16'h7FFF, 1, 0), 1);
    send_beam(make_beam(16'hFFFF, 16'h8000, 1, 1), 1);
    send_beam(make_beam(16'hFFFF, 16'h4000, 1, 0), 1);
    send_beam(make_beam(16'hFFFF, 16'hC000, 1, 0), 1);
    send_beam(make_beam(16'd1000, 16'd0, 0, 0), 1);
    send_beam(make_beam(16'd330, 16'd0, 1, 0), 1);
    send_beam(make_beam(16'd329, 16'd0, 1, 0), 1);
    send_beam(make_beam(16'd290, 16'h8000, 1, 0), 1);
    send_beam(make_beam(16'd250, 16'h4000, 1, 0), 1);
    send_beam(make_beam(16'd250, 16'hC000, 1, 1), 0);
    drain_points();

    // Extreme registers: origin cancel, yaw wrap, zero and full footprints.
    write_reg(lptf_pkg::RegSensorX, 16'h8000);
    write_reg(lptf_pkg::RegSensorY, 16'h7FFF);
    write_reg(lptf_pkg::RegSensorYaw, 16'h7FFF);
    write_reg(lptf_pkg::RegFront, 16'h0000);
    write_reg(lptf_pkg::RegRear, 16'h7FFF);
    write_reg(lptf_pkg::RegLeft, 16'hFFFF);
    write_reg(lptf_pkg::RegRight, 16'h0000);
    write_reg(3'd7, 16'h1234);
    send_beam(make_beam(16'hFFFF, 16'h7FFF, 1, 0), 1);
    send_beam(make_beam(16'd0, 16'h8000, 1, 1), 1);
    send_beam(make_beam(16'd5000, 16'h0001, 1, 0), 0);
    drain_points();
    write_reg(lptf_pkg::RegSensorX, 16'd100);
    write_reg(lptf_pkg::RegSensorY, 16'd0);
    write_reg(lptf_pkg::RegSensorYaw, 16'h8000);
    write_reg(lptf_pkg::RegFront, 16'h7FFF);
    write_reg(lptf_pkg::RegRear, 16'h0000);
    write_reg(lptf_pkg::RegLeft, 16'h0000);
    write_reg(lptf_pkg::RegRight, 16'h7FFF);
    send_beam(make_beam(16'd100, 16'h8000, 1, 0), 1);
    send_beam(make_beam(16'd100, 16'h0000, 1, 0), 0);
    drain_points();

    for (int phase = 0; phase < 5; phase++) begin
      write_reg(lptf_pkg::RegSensorX,
                (phase == 4) ? 16'h7FFF : 16'($urandom_range(0, 800) - 400));
      write_reg(lptf_pkg::RegSensorY,
                (phase == 4) ? 16'h8000 : 16'($urandom_range(0, 800) - 400));
      write_reg(lptf_pkg::RegSensorYaw, 16'($urandom));
      write_reg(lptf_pkg::RegFront, 16'($urandom_range(0, 600)));
      write_reg(lptf_pkg::RegRear, 16'($urandom_range(0, 600)));
      write_reg(lptf_pkg::RegLeft, 16'($urandom_range(0, 600)));
      write_reg(lptf_pkg::RegRight, 16'($urandom_range(0, 600)));
      random_beams(170);
      drain_points();
    end

    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/lptf_pkg.sv
rtl/lptf_cell.sv
rtl/lptf_chain.sv
rtl/lidar_point_transform_filter.sv
tb/lptf_checker.sv
tb/testbench.sv
